// ===== design/bcle_pkg.sv =====
// Package for the battery charge level estimator.
// Holds the shared constants, the millivolt level table and the controller/datapath structs.
// Depends on nothing; every other design file refers to it by scoped names.
package bcle_pkg;

    // Default width of one raw converter sample.
    localparam int SAMPLE_BITS_DEF = 12;

    // Samples are counted in eight bits, so the sum needs eight bits of headroom.
    localparam int COUNT_W = 8;
    localparam int CONV_W  = 16;
    localparam int MV_W    = 16;
    localparam int PCT_W   = 7;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_READS_PER_AVERAGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONV_FACTOR       = 2'd1;

    localparam logic [COUNT_W-1:0] READS_PER_AVERAGE_RST = 8'd20;
    localparam logic [CONV_W-1:0]  CONV_FACTOR_RST       = 16'd435;

    // Charge level search.
    localparam int TABLE_ENTRIES = 101;
    localparam int STEP_W        = 5;
    localparam int SEARCH_STEPS  = 5;
    localparam logic [MV_W-1:0]   FULL_MV      = 16'd4200;
    localparam logic [MV_W-1:0]   EMPTY_MV     = 16'd3200;
    localparam logic [PCT_W-1:0]  PERCENT_FULL = 7'd100;
    localparam logic [PCT_W-1:0]  PERCENT_NONE = 7'd0;
    localparam logic [PCT_W-1:0]  SEARCH_START = 7'd50;
    // Later step sizes (12, 6, 3, 1) are this value halved each step.
    localparam logic [STEP_W-1:0] STEP_FIRST   = 5'd25;

    // Cell voltage in millivolts for each percent of charge.
    localparam logic [MV_W-1:0] LEVEL_MV [0:TABLE_ENTRIES-1] = '{
        16'd3200,
        16'd3250, 16'd3300, 16'd3350, 16'd3400, 16'd3450,
        16'd3500, 16'd3550, 16'd3600, 16'd3650, 16'd3700,
        16'd3703, 16'd3706, 16'd3710, 16'd3713, 16'd3716,
        16'd3719, 16'd3723, 16'd3726, 16'd3729, 16'd3732,
        16'd3735, 16'd3739, 16'd3742, 16'd3745, 16'd3748,
        16'd3752, 16'd3755, 16'd3758, 16'd3761, 16'd3765,
        16'd3768, 16'd3771, 16'd3774, 16'd3777, 16'd3781,
        16'd3784, 16'd3787, 16'd3790, 16'd3794, 16'd3797,
        16'd3800, 16'd3805, 16'd3811, 16'd3816, 16'd3821,
        16'd3826, 16'd3832, 16'd3837, 16'd3842, 16'd3847,
        16'd3853, 16'd3858, 16'd3863, 16'd3868, 16'd3874,
        16'd3879, 16'd3884, 16'd3889, 16'd3895, 16'd3900,
        16'd3906, 16'd3911, 16'd3917, 16'd3922, 16'd3928,
        16'd3933, 16'd3939, 16'd3944, 16'd3950, 16'd3956,
        16'd3961, 16'd3967, 16'd3972, 16'd3978, 16'd3983,
        16'd3989, 16'd3994, 16'd4000, 16'd4008, 16'd4015,
        16'd4023, 16'd4031, 16'd4038, 16'd4046, 16'd4054,
        16'd4062, 16'd4069, 16'd4077, 16'd4085, 16'd4092,
        16'd4100, 16'd4111, 16'd4122, 16'd4133, 16'd4144,
        16'd4156, 16'd4167, 16'd4178, 16'd4189, 16'd4200
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accum;
        logic div_step;
        logic mult;
        logic srch_init;
        logic srch_step;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic batch_done;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== design/bcle_ctrl.sv =====
// Controller state machine of the battery charge level estimator.
// Sequences accumulate, divide, multiply, saturate, search and result load.
// Depends on bcle_pkg for the command and status structs.
module bcle_ctrl #(
    parameter int SAMPLE_BITS = bcle_pkg::SAMPLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  bcle_pkg::t_dp_stat i_stat,
    output logic               o_ready,
    output bcle_pkg::t_dp_cmd  o_cmd
);

    localparam int CNT_W = $clog2(SAMPLE_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_SAT,
        S_SRCH,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd           = '0;
        o_cmd.accum     = (r_state == S_IDLE) && i_valid;
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.mult      = (r_state == S_MUL);
        o_cmd.srch_init = (r_state == S_SAT);
        o_cmd.srch_step = (r_state == S_SRCH);
        o_cmd.load_out  = (r_state == S_DONE) && i_stat.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid && i_stat.batch_done) begin
                        r_state <= S_DIV;
                        r_cnt   <= CNT_W'(SAMPLE_BITS - 1);
                    end
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_MUL;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_MUL: begin
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_state <= S_SRCH;
                    r_cnt   <= CNT_W'(bcle_pkg::SEARCH_STEPS - 1);
                end
                S_SRCH: begin
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_DONE: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/bcle_datapath.sv =====
// Datapath of the battery charge level estimator: configuration registers, sample
// accumulator, restoring divider, Q8.8 multiplier, level search and output register.
// Depends on bcle_pkg; driven by commands from bcle_ctrl.
module bcle_datapath #(
    parameter int SAMPLE_BITS = bcle_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bcle_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bcle_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [SAMPLE_BITS-1:0]              i_sample,
    input  logic                                i_ready,
    input  bcle_pkg::t_dp_cmd                   i_cmd,
    output bcle_pkg::t_dp_stat                  o_stat,
    output logic                                o_valid,
    output logic [bcle_pkg::PCT_W-1:0]          o_charge_percent,
    output logic [bcle_pkg::MV_W-1:0]           o_millivolts,
    output logic [SAMPLE_BITS-1:0]              o_average_raw
);

    localparam int CW     = bcle_pkg::COUNT_W;
    localparam int SUM_W  = SAMPLE_BITS + CW;
    localparam int PROD_W = SAMPLE_BITS + bcle_pkg::CONV_W;
    localparam int MVF_W  = PROD_W - 8;
    localparam logic [MVF_W-1:0] MV_MAX = MVF_W'(65535);

    // Configuration.
    logic [CW-1:0]                   r_rpa;
    logic [bcle_pkg::CONV_W-1:0]     r_conv;

    // Accumulator.
    logic [SUM_W-1:0]                r_sum;
    logic [CW-1:0]                   r_count;
    logic [SUM_W-1:0]                w_sum_next;
    logic [CW-1:0]                   w_count_next;
    logic [CW-1:0]                   w_target;

    // Divider: r_quo starts as the low dividend bits and fills with quotient bits.
    logic [CW-1:0]                   r_rem;
    logic [CW-1:0]                   r_divisor;
    logic [SAMPLE_BITS-1:0]          r_quo;
    logic [CW:0]                     w_trial;
    logic                            w_fits;

    // Conversion and search.
    logic [PROD_W-1:0]               r_prod;
    logic [MVF_W-1:0]                w_mv_full;
    logic [bcle_pkg::MV_W-1:0]       r_mv;
    logic [bcle_pkg::PCT_W-1:0]      r_idx;
    logic [bcle_pkg::STEP_W-1:0]     r_stepsz;
    logic [bcle_pkg::MV_W-1:0]       w_entry;
    logic [bcle_pkg::PCT_W-1:0]      w_percent;

    // Output register.
    logic                            r_out_valid;
    logic [bcle_pkg::PCT_W-1:0]      r_out_pct;
    logic [bcle_pkg::MV_W-1:0]       r_out_mv;
    logic [SAMPLE_BITS-1:0]          r_out_avg;

    assign w_sum_next   = r_sum + SUM_W'(i_sample);
    assign w_count_next = r_count + 1'b1;
    assign w_target     = (r_rpa == '0) ? CW'(1) : r_rpa;

    assign w_trial = {r_rem, r_quo[SAMPLE_BITS-1]};
    assign w_fits  = (w_trial >= {1'b0, r_divisor});

    assign w_mv_full = r_prod[PROD_W-1:8];
    assign w_entry   = bcle_pkg::LEVEL_MV[r_idx];

    always_comb begin
        if (r_mv >= bcle_pkg::FULL_MV) begin
            w_percent = bcle_pkg::PERCENT_FULL;
        end else if (r_mv <= bcle_pkg::EMPTY_MV) begin
            w_percent = bcle_pkg::PERCENT_NONE;
        end else begin
            w_percent = r_idx;
        end
    end

    assign o_stat.batch_done = (w_count_next >= w_target);
    assign o_stat.out_free   = !r_out_valid || i_ready;

    // Control state: configuration, accumulator and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpa       <= bcle_pkg::READS_PER_AVERAGE_RST;
            r_conv      <= bcle_pkg::CONV_FACTOR_RST;
            r_sum       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bcle_pkg::CFG_READS_PER_AVERAGE: r_rpa  <= i_cfg_data[CW-1:0];
                    bcle_pkg::CFG_CONV_FACTOR:       r_conv <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.accum) begin
                if (o_stat.batch_done) begin
                    r_sum   <= '0;
                    r_count <= '0;
                end else begin
                    r_sum   <= w_sum_next;
                    r_count <= w_count_next;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accum && o_stat.batch_done) begin
            // The quotient fits in SAMPLE_BITS bits, so the top byte of the sum is
            // already below the divisor and seeds the partial remainder.
            r_rem     <= w_sum_next[SUM_W-1:SAMPLE_BITS];
            r_quo     <= w_sum_next[SAMPLE_BITS-1:0];
            r_divisor <= w_count_next;
        end else if (i_cmd.div_step) begin
            r_rem <= w_fits ? CW'(w_trial - {1'b0, r_divisor}) : w_trial[CW-1:0];
            r_quo <= {r_quo[SAMPLE_BITS-2:0], w_fits};
        end
        if (i_cmd.mult) begin
            r_prod <= PROD_W'(r_quo) * PROD_W'(r_conv);
        end
        if (i_cmd.srch_init) begin
            r_mv     <= (w_mv_full > MV_MAX) ? '1 : w_mv_full[bcle_pkg::MV_W-1:0];
            r_idx    <= bcle_pkg::SEARCH_START;
            r_stepsz <= bcle_pkg::STEP_FIRST;
        end else if (i_cmd.srch_step) begin
            if (r_mv >= w_entry) begin
                r_idx <= r_idx + bcle_pkg::PCT_W'(r_stepsz);
            end else begin
                r_idx <= r_idx - bcle_pkg::PCT_W'(r_stepsz);
            end
            r_stepsz <= r_stepsz >> 1;
        end
        if (i_cmd.load_out) begin
            r_out_pct <= w_percent;
            r_out_mv  <= r_mv;
            r_out_avg <= r_quo;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_charge_percent = r_out_pct;
    assign o_millivolts     = r_out_mv;
    assign o_average_raw    = r_out_avg;

endmodule

// ===== design/battery_charge_level_estimator.sv =====
// Battery charge level estimator. Each accepted sample beat is added to a running
// sum; when the number of summed samples reaches reads_per_average (zero counts as
// one), the block produces one result beat holding the truncated average, the cell
// voltage in millivolts ((average * conv_factor) >> 8, saturated at 65535) and the
// charge in percent (100 at 4200 mV or above, 0 at 3200 mV or below, otherwise a
// five-step halving search over a 101-entry voltage table), then clears the sum.
// A sample that does not complete a batch is only added to the sum and the input
// stays ready. A sample that completes a batch is accumulated and then passes through
// the bit-serial restoring divider, the multiply, the saturation, the search and the
// load of the output register; the input is not ready during that time.
// The output register holds a finished result until it is taken, and new samples
// are accepted meanwhile; a following result waits in the done state until the
// output register frees up. Configuration writes take effect at once and should
// only be made while no batch is being processed; the sum and count are kept.
module battery_charge_level_estimator #(
    parameter int SAMPLE_BITS = bcle_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [bcle_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bcle_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Sample input channel.
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [SAMPLE_BITS-1:0]          i_sample,
    // Result output channel.
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [bcle_pkg::PCT_W-1:0]      o_charge_percent,
    output logic [bcle_pkg::MV_W-1:0]       o_millivolts,
    output logic [SAMPLE_BITS-1:0]          o_average_raw
);

    bcle_pkg::t_dp_cmd  w_cmd;
    bcle_pkg::t_dp_stat w_stat;

    // The controller only sequences; all data arithmetic and storage is in the datapath.
    bcle_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (w_stat),
        .o_ready (o_ready),
        .o_cmd   (w_cmd)
    );

    bcle_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_sample         (i_sample),
        .i_ready          (i_ready),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_valid          (o_valid),
        .o_charge_percent (o_charge_percent),
        .o_millivolts     (o_millivolts),
        .o_average_raw    (o_average_raw)
    );

endmodule

// ===== design/bcle_checker.sv =====
// Port-level checker for the battery charge level estimator, with its bind statement.
// Depends on bcle_pkg and on the ports of battery_charge_level_estimator.
module bcle_checker #(
    parameter int SAMPLE_BITS = bcle_pkg::SAMPLE_BITS_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic [bcle_pkg::PCT_W-1:0] o_charge_percent,
    input logic [bcle_pkg::MV_W-1:0]  o_millivolts,
    input logic [SAMPLE_BITS-1:0]     o_average_raw
);

    // A result beat left waiting keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_charge_percent)
            && $stable(o_millivolts) && $stable(o_average_raw))
        else $error("result beat changed while stalled");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_charge_percent <= bcle_pkg::PERCENT_FULL)
        else $error("charge percent above full");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_millivolts >= bcle_pkg::FULL_MV
            |-> o_charge_percent == bcle_pkg::PERCENT_FULL)
        else $error("full voltage not reported as full charge");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_millivolts <= bcle_pkg::EMPTY_MV
            |-> o_charge_percent == bcle_pkg::PERCENT_NONE)
        else $error("empty voltage not reported as zero charge");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind battery_charge_level_estimator bcle_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_bcle_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_charge_percent (o_charge_percent),
    .o_millivolts     (o_millivolts),
    .o_average_raw    (o_average_raw)
);
